### rtl/tvsc_pkg.sv
// ----------------------------------------------------------------------------
// tvsc_pkg
// Shared widths, command and redraw codes, and saturation helpers for the
// tile viewport scroll controller.
// ----------------------------------------------------------------------------
package tvsc_pkg;

	// field widths
	localparam int CMD_W    = 3;
	localparam int AMT_W    = 8;
	localparam int POS_W    = 12;
	localparam int TILE_W   = 8;
	localparam int FINE_W   = 6;
	localparam int REDRAW_W = 4;
	localparam int WORLD_W  = 15;

	// stream payload widths
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 40;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_COLUMNS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS    = 1'd1;

	localparam logic [7:0] MAP_COLUMNS_RST = 8'd22;
	localparam logic [7:0] MAP_ROWS_RST    = 8'd15;

	// command codes
	localparam logic [CMD_W-1:0] CMD_UP    = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DOWN  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIX   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_JUMP  = 3'd5;

	// redraw codes reported by the fix command
	localparam logic [REDRAW_W-1:0] RD_NONE       = 4'd0;
	localparam logic [REDRAW_W-1:0] RD_FULL       = 4'd1;
	localparam logic [REDRAW_W-1:0] RD_LEFT_UP    = 4'd2;
	localparam logic [REDRAW_W-1:0] RD_LEFT_DOWN  = 4'd3;
	localparam logic [REDRAW_W-1:0] RD_RIGHT_UP   = 4'd4;
	localparam logic [REDRAW_W-1:0] RD_RIGHT_DOWN = 4'd5;
	localparam logic [REDRAW_W-1:0] RD_LEFT       = 4'd6;
	localparam logic [REDRAW_W-1:0] RD_RIGHT      = 4'd7;
	localparam logic [REDRAW_W-1:0] RD_UP         = 4'd8;
	localparam logic [REDRAW_W-1:0] RD_DOWN       = 4'd9;

	// moved flag bits
	localparam int FLAG_LEFT  = 0;
	localparam int FLAG_RIGHT = 1;
	localparam int FLAG_UP    = 2;
	localparam int FLAG_DOWN  = 3;

	// offsets placed at the world limit
	localparam logic [FINE_W-1:0] EDGE_FINE_X = 6'd32;
	localparam logic [FINE_W-1:0] EDGE_FINE_Y = 6'd40;

	typedef logic signed [WORLD_W-1:0] world_t;

	// placed position of one axis
	typedef struct packed {
		logic [TILE_W-1:0] org;
		logic [FINE_W-1:0] off;
	} axis_pos_t;

	// clamp a world value into 0..4095
	function automatic logic [POS_W-1:0] sat12(input world_t v);
		logic [POS_W-1:0] r;
		if (v < 0)
			r = '0;
		else if (v > world_t'(4095))
			r = '1;
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

	// clamp a world value into 0..255
	function automatic logic [TILE_W-1:0] sat8(input world_t v);
		logic [TILE_W-1:0] r;
		if (v < 0)
			r = '0;
		else if (v > world_t'(255))
			r = '1;
		else
			r = v[TILE_W-1:0];
		return r;
	endfunction

endpackage

### rtl/tvsc_place.sv
// ----------------------------------------------------------------------------
// tvsc_place
// Places one viewport axis on a world pixel: tile origin plus fine offset,
// with the origin pinned near the world limit.
// ----------------------------------------------------------------------------
module tvsc_place import tvsc_pkg::*; (
	input  logic [POS_W-1:0]  pix,      // world pixel on this axis
	input  world_t            lim,      // world limit on this axis
	input  logic [TILE_W-1:0] lim_org,  // origin used at the limit
	input  logic [FINE_W-1:0] edge_off, // offset used at the limit
	output axis_pos_t         pos
);

	world_t pix_s;

	assign pix_s = world_t'({3'b000, pix});

	// pick the near-zero, limit or interior placement
	always_comb begin
		if (pix[POS_W-1:4] == '0) begin
			pos.org = '0;
			pos.off = {2'b00, pix[3:0]};
		end else if (pix_s >= lim) begin
			pos.org = lim_org;
			pos.off = edge_off;
		end else begin
			pos.org = pix[POS_W-1:4] - 8'd1;
			pos.off = {2'b01, pix[3:0]};
		end
	end

endmodule

### rtl/tile_viewport_scroll_controller.sv
// ----------------------------------------------------------------------------
// tile_viewport_scroll_controller
// Tracks a tile-map viewport (tile origin plus fine offset) under scroll,
// fix and jump requests; one result per request.
// ----------------------------------------------------------------------------
// Output: each result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one request per cycle; the whole update is one pass of logic
// between the viewport registers and a two-entry result buffer, so input
// stalls only when both buffer entries hold untaken results.
// Reset: viewport, pending target and flags clear to zero; map_columns = 22,
// map_rows = 15; the result buffer empties.
// ----------------------------------------------------------------------------
module tile_viewport_scroll_controller import tvsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,  // amount, target_x, target_y
	input  logic [CMD_W-1:0]     s_tuser,  // cmd
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata   // failed, tile_col, tile_row,
	                                       // fine_x, fine_y, redraw_case, pad
);

	// configuration and viewport state
	logic [7:0]          map_columns_q, map_rows_q;
	logic [TILE_W-1:0]   origin_col_q, origin_row_q;
	logic [FINE_W-1:0]   offset_x_q, offset_y_q;
	logic [POS_W-1:0]    pending_x_q, pending_y_q;
	logic                jump_pending_q;
	logic [3:0]          moved_flags_q;

	logic [TILE_W-1:0]   origin_col_d, origin_row_d;
	logic [FINE_W-1:0]   offset_x_d, offset_y_d;
	logic [POS_W-1:0]    pending_x_d, pending_y_d;
	logic                jump_pending_d;
	logic [3:0]          moved_flags_d;
	logic                failed_d;
	logic [REDRAW_W-1:0] redraw_d;

	// result buffer
	logic                out_v_q, skid_v_q;
	logic [M_DATA_W-1:0] out_q, skid_q;
	logic [M_DATA_W-1:0] result;

	logic                s_req;
	logic [CMD_W-1:0]    cmd;
	logic [AMT_W-1:0]    amount;
	logic [POS_W-1:0]    target_x, target_y;

	world_t              cols_s, rows_s, lim_x, lim_y, wx, wy, amt_s;
	world_t              lim_y_tile, wx_next, wy_next;
	logic [TILE_W-1:0]   lim_org_x, lim_org_y;
	logic [POS_W-1:0]    place_x, place_y;
	axis_pos_t           pos_x, pos_y;
	logic                small_v, small_h;

	assign cmd      = s_tuser;
	assign amount   = s_tdata[7:0];
	assign target_x = s_tdata[19:8];
	assign target_y = s_tdata[31:20];

	assign s_tready = !skid_v_q;
	assign s_req    = s_tvalid && s_tready;

	// world limits and the origins they pin
	assign cols_s = world_t'({7'b0, map_columns_q});
	assign rows_s = world_t'({7'b0, map_rows_q});
	assign lim_x  = (cols_s - world_t'(20)) <<< 4;
	assign lim_y  = ((rows_s - world_t'(12)) <<< 4) - world_t'(8);
	assign lim_y_tile = (map_rows_q >= 8'd13) ? rows_s - world_t'(13) : rows_s - world_t'(12);
	assign lim_org_x  = sat8(cols_s - world_t'(22));
	assign lim_org_y  = sat8(lim_y_tile - world_t'(2));

	// current world position
	assign wx    = world_t'({3'b0, origin_col_q, 4'b0000}) + world_t'({9'b0, offset_x_q});
	assign wy    = world_t'({3'b0, origin_row_q, 4'b0000}) + world_t'({9'b0, offset_y_q});
	assign amt_s = world_t'({7'b0, amount});

	assign small_v = (amount < 8'd16);
	assign small_h = (amount <= 8'd16);

	// jump source: pending target on fix, request target otherwise
	assign place_x = (cmd == CMD_FIX) ? pending_x_q : target_x;
	assign place_y = (cmd == CMD_FIX) ? pending_y_q : target_y;

	tvsc_place u_place_x (
		.pix      (place_x),
		.lim      (lim_x),
		.lim_org  (lim_org_x),
		.edge_off (EDGE_FINE_X),
		.pos      (pos_x)
	);

	tvsc_place u_place_y (
		.pix      (place_y),
		.lim      (lim_y),
		.lim_org  (lim_org_y),
		.edge_off (EDGE_FINE_Y),
		.pos      (pos_y)
	);

	// next viewport state for the request at the input
	always_comb begin
		origin_col_d   = origin_col_q;
		origin_row_d   = origin_row_q;
		offset_x_d     = offset_x_q;
		offset_y_d     = offset_y_q;
		pending_x_d    = pending_x_q;
		pending_y_d    = pending_y_q;
		jump_pending_d = jump_pending_q;
		moved_flags_d  = moved_flags_q;
		failed_d       = 1'b0;
		redraw_d       = RD_NONE;
		wx_next        = wx;
		wy_next        = wy;

		unique case (cmd)
			CMD_UP: begin
				if (!small_v) begin
					wy_next        = (wy - amt_s < 0) ? '0 : wy - amt_s;
					pending_x_d    = sat12(wx);
					pending_y_d    = sat12(wy_next);
					jump_pending_d = 1'b1;
				end else if ({2'b00, offset_y_q} >= amount) begin
					offset_y_d = offset_y_q - amount[FINE_W-1:0];
				end else if (origin_row_q != '0) begin
					origin_row_d           = origin_row_q - 8'd1;
					offset_y_d             = offset_y_q + 6'd16 - amount[FINE_W-1:0];
					moved_flags_d[FLAG_UP] = 1'b1;
				end else begin
					failed_d = 1'b1;
				end
			end
			CMD_DOWN: begin
				if (!small_v) begin
					wy_next        = (wy + amt_s < lim_y) ? wy + amt_s : lim_y;
					pending_x_d    = sat12(wx);
					pending_y_d    = sat12(wy_next);
					jump_pending_d = 1'b1;
				end else if ({2'b00, offset_y_q} + amount <= 8'd40) begin
					offset_y_d = offset_y_q + amount[FINE_W-1:0];
				end else if ({1'b0, origin_row_q} + 9'd15 < {1'b0, map_rows_q}) begin
					origin_row_d             = origin_row_q + 8'd1;
					offset_y_d               = offset_y_q - 6'd16 + amount[FINE_W-1:0];
					moved_flags_d[FLAG_DOWN] = 1'b1;
				end else begin
					failed_d = 1'b1;
				end
			end
			CMD_LEFT: begin
				if (!small_h) begin
					wx_next        = (wx - amt_s < 0) ? '0 : wx - amt_s;
					pending_x_d    = sat12(wx_next);
					pending_y_d    = sat12(wy);
					jump_pending_d = 1'b1;
				end else if ({2'b00, offset_x_q} >= amount) begin
					offset_x_d = offset_x_q - amount[FINE_W-1:0];
				end else if (origin_col_q != '0) begin
					origin_col_d             = origin_col_q - 8'd1;
					offset_x_d               = offset_x_q + 6'd16 - amount[FINE_W-1:0];
					moved_flags_d[FLAG_LEFT] = 1'b1;
				end else begin
					failed_d = 1'b1;
				end
			end
			CMD_RIGHT: begin
				if (!small_h) begin
					wx_next        = (wx + amt_s < lim_x) ? wx + amt_s : lim_x;
					pending_x_d    = sat12(wx_next);
					pending_y_d    = sat12(wy);
					jump_pending_d = 1'b1;
				end else if ({2'b00, offset_x_q} + amount <= 8'd32) begin
					offset_x_d = offset_x_q + amount[FINE_W-1:0];
				end else if ({1'b0, origin_col_q} + 9'd22 < {1'b0, map_columns_q}) begin
					origin_col_d              = origin_col_q + 8'd1;
					offset_x_d                = offset_x_q - 6'd16 + amount[FINE_W-1:0];
					moved_flags_d[FLAG_RIGHT] = 1'b1;
				end else begin
					failed_d = 1'b1;
				end
			end
			CMD_FIX: begin
				// report a full redraw on a pending jump, else corner cases ahead of single edges
				if (jump_pending_q) begin
					redraw_d     = RD_FULL;
					origin_col_d = pos_x.org;
					offset_x_d   = pos_x.off;
					origin_row_d = pos_y.org;
					offset_y_d   = pos_y.off;
				end else if (moved_flags_q[FLAG_LEFT] && moved_flags_q[FLAG_UP]) begin
					redraw_d = RD_LEFT_UP;
				end else if (moved_flags_q[FLAG_LEFT] && moved_flags_q[FLAG_DOWN]) begin
					redraw_d = RD_LEFT_DOWN;
				end else if (moved_flags_q[FLAG_RIGHT] && moved_flags_q[FLAG_UP]) begin
					redraw_d = RD_RIGHT_UP;
				end else if (moved_flags_q[FLAG_RIGHT] && moved_flags_q[FLAG_DOWN]) begin
					redraw_d = RD_RIGHT_DOWN;
				end else if (moved_flags_q[FLAG_LEFT]) begin
					redraw_d = RD_LEFT;
				end else if (moved_flags_q[FLAG_RIGHT]) begin
					redraw_d = RD_RIGHT;
				end else if (moved_flags_q[FLAG_UP]) begin
					redraw_d = RD_UP;
				end else if (moved_flags_q[FLAG_DOWN]) begin
					redraw_d = RD_DOWN;
				end
				moved_flags_d  = '0;
				jump_pending_d = 1'b0;
			end
			CMD_JUMP: begin
				origin_col_d = pos_x.org;
				offset_x_d   = pos_x.off;
				origin_row_d = pos_y.org;
				offset_y_d   = pos_y.off;
			end
			default: begin
				// unused codes leave the viewport alone
			end
		endcase
	end

	// pack the result fields from the lowest bit up
	assign result = {7'b0, redraw_d, offset_y_d, offset_x_d,
	                 origin_row_d, origin_col_d, failed_d};

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_columns_q <= MAP_COLUMNS_RST;
			map_rows_q    <= MAP_ROWS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_COLUMNS: map_columns_q <= cfg_data;
				REG_MAP_ROWS:    map_rows_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// advance the viewport state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_col_q   <= '0;
			origin_row_q   <= '0;
			offset_x_q     <= '0;
			offset_y_q     <= '0;
			pending_x_q    <= '0;
			pending_y_q    <= '0;
			jump_pending_q <= 1'b0;
			moved_flags_q  <= '0;
		end else if (s_req) begin
			origin_col_q   <= origin_col_d;
			origin_row_q   <= origin_row_d;
			offset_x_q     <= offset_x_d;
			offset_y_q     <= offset_y_d;
			pending_x_q    <= pending_x_d;
			pending_y_q    <= pending_y_d;
			jump_pending_q <= jump_pending_d;
			moved_flags_q  <= moved_flags_d;
		end
	end

	// hold results in the output register, spill into the skid entry on stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			out_v_q  <= skid_v_q || s_req;
			skid_v_q <= 1'b0;
		end else if (s_req) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : result;
		end else if (s_req) begin
			skid_q <= result;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

endmodule
